// ----- hw/rtl/flight_sequencer_ping_pong_capture_top_defines.svh -----
`ifndef FLIGHT_SEQUENCER_PING_PONG_CAPTURE_TOP_DEFINES_SVH
`define FLIGHT_SEQUENCER_PING_PONG_CAPTURE_TOP_DEFINES_SVH

// Same-cycle implication, checked on every clk edge outside reset.
`define FSPPC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define FSPPC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/fsppc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package fsppc_pkg;

	localparam int CAPTURE_WIDTH_DEF = 16;
	localparam int VALUE_W           = 16;
	localparam int STORE_DEPTH       = 8;
	localparam int QUEUE_DEPTH       = 3;

	typedef enum logic [2:0] {
		OP_CAPTURE  = 3'd0,
		OP_VALIDATE = 3'd1,
		OP_NEXT     = 3'd2,
		OP_READ     = 3'd3,
		OP_RELEASE  = 3'd4
	} op_t;

	typedef logic [1:0] flight_t;

	// Transducer addresses per flight: N-S, S-N, E-W, W-E.
	localparam logic [1:0] TX_ADDR [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
	localparam logic [1:0] RX_ADDR [4] = '{2'd0, 2'd3, 2'd2, 2'd1};

	typedef struct packed {
		logic               ready_res;
		logic [VALUE_W-1:0] read_value;
		flight_t            flight_now;
		logic [1:0]         transmit_address;
		logic [1:0]         receive_address;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/fsppc_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsppc_ram #(
	parameter int  WIDTH = 16,
	parameter int  DEPTH = 8,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/fsppc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsppc_ctrl #(
	parameter int CAPTURE_WIDTH = fsppc_pkg::CAPTURE_WIDTH_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire fsppc_pkg::op_t               op,
	input  wire logic [fsppc_pkg::VALUE_W-1:0] capture_value,
	input  wire logic [1:0]                   slot,
	output logic                              res_valid,
	output fsppc_pkg::res_t                   res
);

	import fsppc_pkg::*;

	`include "flight_sequencer_ping_pong_capture_top_defines.svh"

	localparam int AW = $clog2(STORE_DEPTH);

	flight_t                  flight_q;
	logic                     whs_q;
	logic                     ready_q;
	logic [CAPTURE_WIDTH-1:0] latch_q;
	logic                     pend_q;
	logic [STORE_DEPTH-1:0]   valid_q;

	logic    valid_s1;
	logic    hit_s1;
	logic    ready_s1;
	flight_t flight_s1;

	logic                         is_cap, is_val, is_next, is_rd, is_rel;
	flight_t                      flight_inc, flight_d;
	logic                         wrap, ready_d, whs_d;
	logic                         we, re;
	logic [AW-1:0]                waddr, raddr;
	logic [CAPTURE_WIDTH-1:0]     wdata, rdata;
	logic [CAPTURE_WIDTH+VALUE_W-1:0] cap_ext;
	logic [CAPTURE_WIDTH+VALUE_W-1:0] rd_ext;

	always_comb begin
		is_cap     = accept && (op == OP_CAPTURE);
		is_val     = accept && (op == OP_VALIDATE);
		is_next    = accept && (op == OP_NEXT);
		is_rd      = accept && (op == OP_READ);
		is_rel     = accept && (op == OP_RELEASE);
		flight_inc = flight_q + 2'd1;
		wrap       = is_next && (flight_inc == 2'd0) && !ready_q;
		flight_d   = is_next ? flight_inc : flight_q;
		whs_d      = wrap ? ~whs_q : whs_q;
		ready_d    = wrap ? 1'b1 : (is_rel ? 1'b0 : ready_q);
		cap_ext    = {{CAPTURE_WIDTH{1'b0}}, capture_value};
		// Write goes to the write half, reads to the other half; one op per word,
		// and a write lands before any later word reads, so no bypass is needed.
		we         = is_val;
		waddr      = {whs_q, flight_q};
		wdata      = pend_q ? latch_q : '0;
		re         = is_rd && ready_q;
		raddr      = {~whs_q, slot};
	end

	fsppc_ram #(
		.WIDTH (CAPTURE_WIDTH),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flight_q <= '0;
			whs_q    <= 1'b0;
			ready_q  <= 1'b0;
			latch_q  <= '0;
			pend_q   <= 1'b0;
			valid_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			flight_q <= flight_d;
			whs_q    <= whs_d;
			ready_q  <= ready_d;
			valid_s1 <= accept;
			if (is_cap) begin
				latch_q <= cap_ext[CAPTURE_WIDTH-1:0];
				pend_q  <= 1'b1;
			end else if (is_val) begin
				pend_q <= 1'b0;
			end
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
		end
	end

	// Payload of the read stage; never-written entries read as zero.
	always_ff @(posedge clk) begin
		hit_s1    <= re && valid_q[raddr];
		ready_s1  <= ready_d;
		flight_s1 <= flight_d;
	end

	always_comb begin
		rd_ext                 = {{VALUE_W{1'b0}}, rdata};
		res_valid              = valid_s1;
		res.ready_res          = ready_s1;
		res.read_value         = hit_s1 ? rd_ext[VALUE_W-1:0] : '0;
		res.flight_now         = flight_s1;
		res.transmit_address   = TX_ADDR[flight_s1];
		res.receive_address    = RX_ADDR[flight_s1];
	end

	`FSPPC_ASSERT_NOW(a_ready_rise_at_wrap, $rose(ready_q), flight_q == 2'd0,
		"ready set away from flight 0")
	`FSPPC_ASSERT_NOW(a_swap_with_ready, whs_q != $past(whs_q),
		ready_q && !$past(ready_q), "buffer swap without ready rising")
	`FSPPC_ASSERT_NEXT(a_validate_clears, is_val, !pend_q,
		"latch still pending after validate")

endmodule

`default_nettype wire

// ----- hw/rtl/fsppc_outq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module fsppc_outq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire fsppc_pkg::res_t push_data,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output fsppc_pkg::res_t      pop_data,
	output logic [1:0]           count
);

	import fsppc_pkg::*;

	`include "flight_sequencer_ping_pong_capture_top_defines.svh"

	res_t       entry_q [QUEUE_DEPTH];
	logic [1:0] wr_q, rd_q, cnt_q;
	logic       pop;

	function automatic logic [1:0] ptr_inc(logic [1:0] p);
		return (p == 2'(QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
	endfunction

	always_comb begin
		pop       = pop_ready && (cnt_q != 2'd0);
		pop_valid = (cnt_q != 2'd0);
		pop_data  = entry_q[rd_q];
		count     = cnt_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	`FSPPC_ASSERT_NOW(a_no_overflow, push && !pop, cnt_q != 2'(QUEUE_DEPTH),
		"word pushed into a full output queue")

endmodule

`default_nettype wire

// ----- hw/rtl/flight_sequencer_ping_pong_capture_top.sv -----
// Channel  Dir  tdata (low bit up)                          tuser
// s_*      in   capture_value[15:0], slot[17:16], pad[23:18]  op[2:0]
// m_*      out  ready_res[0], read_value[16:1], flight_now[18:17],
//               transmit_address[20:19], receive_address[22:21], pad[23]   -
//
// One word per cycle sustained while m_tready drains the output queue; each result
// goes through the registered read of the capture store and then the output queue
// before it is taken. Flight, ready and latch state update at the accepting edge.
// Reset is immediate: no clearing pass, never-written store entries read as zero.
// s_tready drops once the output queue and the read stage together hold three words.
`timescale 1ns / 1ps
`default_nettype none

module flight_sequencer_ping_pong_capture_top #(
	parameter int CAPTURE_WIDTH = fsppc_pkg::CAPTURE_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [23:0] s_tdata,   // capture_value, slot
	input  wire logic [2:0]  s_tuser,   // op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata    // ready_res, read_value, flight_now, tx, rx
);

	import fsppc_pkg::*;

	logic       accept;
	logic       res_valid;
	res_t       res, out_res;
	logic [1:0] q_count;
	logic [2:0] in_flight;

	always_comb begin
		in_flight = {1'b0, q_count} + {2'b00, res_valid};
		s_tready  = (in_flight < 3'(QUEUE_DEPTH));
		accept    = s_tvalid && s_tready;
	end

	fsppc_ctrl #(
		.CAPTURE_WIDTH (CAPTURE_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.op            (op_t'(s_tuser)),
		.capture_value (s_tdata[15:0]),
		.slot          (s_tdata[17:16]),
		.res_valid     (res_valid),
		.res           (res)
	);

	fsppc_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.pop_valid (m_tvalid),
		.pop_ready (m_tready),
		.pop_data  (out_res),
		.count     (q_count)
	);

	assign m_tdata = {1'b0, out_res.receive_address, out_res.transmit_address,
		out_res.flight_now, out_res.read_value, out_res.ready_res};

endmodule

`default_nettype wire
